FILE: design/ufs_pkg.sv
// Shared types and constants for the UTF-8 field sanitizer.
// No dependencies; imported by every module of the block.
`default_nettype none
package ufs_pkg;

  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_CAPACITY);

  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CH_QMARK = 8'h3F;
  localparam logic [7:0]  CH_DEL   = 8'h7F;
  localparam logic [7:0]  CH_NUL   = 8'h00;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_MIN_2B  = 21'h000080;
  localparam logic [20:0] CP_MIN_3B  = 21'h000800;
  localparam logic [20:0] CP_MIN_4B  = 21'h010000;

  // One transaction's worth of output bytes, up to four.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            last;
  } ufs_entry_t;

  typedef struct packed {
    logic       push;
    ufs_entry_t entry;
  } ufs_qwr_t;

  typedef struct packed {
    logic       valid;
    ufs_entry_t entry;
  } ufs_qrd_t;

endpackage
`default_nettype wire

FILE: design/ufs_front.sv
// Front end: accepts input transactions, tracks the open UTF-8 sequence
// and the byte budget, and pushes at most one entry of result bytes. Uses ufs_pkg.
`default_nettype none
module ufs_front
  import ufs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_field,
  input  wire logic [CAP_W-1:0] capacity,
  input  wire logic             q_room,
  output ufs_qwr_t              qwr
);

  logic [2:0][7:0]   pend;
  logic [2:0][7:0]   pend_next;
  logic [1:0]        pend_count, pend_count_next;
  logic [1:0]        trail, trail_next;
  logic [20:0]       acc, acc_next;
  logic [CAP_W-1:0]  used, used_next;
  logic              full, full_next;

  logic              accept;
  logic [CAP_W-1:0]  eff_cap;
  logic [CAP_W:0]    avail_s;
  logic [CAP_W-1:0]  rm;
  logic [CAP_W-1:0]  need;
  logic              fits;
  logic              is_ascii, is_ctl, lead2, lead3, lead4, is_cont;
  logic [20:0]       acc_cont;
  logic [20:0]       cp_lo;
  logic              cp_ok;
  ufs_entry_t        ent;

  assign accept   = in_valid & in_ready;
  assign in_ready = q_room;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) eff_cap = CAP_W'(1);
    if (capacity > CAP_MAX) eff_cap = CAP_MAX;
  end

  // Bytes still allowed before the closing NUL, clamped at zero.
  assign avail_s = {1'b0, eff_cap} - (CAP_W+1)'(1) - {1'b0, used};
  assign rm      = avail_s[CAP_W] ? '0 : avail_s[CAP_W-1:0];
  assign need    = CAP_W'(pend_count) + CAP_W'(1);
  assign fits    = rm >= need;

  assign is_ascii = ~in_byte[7];
  assign is_ctl   = (in_byte < CH_SPACE) | (in_byte == CH_DEL);
  assign lead2    = in_byte[7:5] == 3'b110;
  assign lead3    = in_byte[7:4] == 4'b1110;
  assign lead4    = in_byte[7:3] == 5'b11110;
  assign is_cont  = in_byte[7:6] == 2'b10;

  assign acc_cont = {acc[14:0], in_byte[5:0]};

  always_comb begin
    case (trail)
      2'd1:    cp_lo = CP_MIN_2B;
      2'd2:    cp_lo = CP_MIN_3B;
      default: cp_lo = CP_MIN_4B;
    endcase
  end

  assign cp_ok = (acc_cont <= CP_MAX) & (acc_cont >= cp_lo)
               & ~((acc_cont >= CP_SUR_LO) & (acc_cont <= CP_SUR_HI));

  always_comb begin
    pend_next       = pend;
    pend_count_next = pend_count;
    trail_next      = trail;
    acc_next        = acc;
    full_next       = full;
    ent.data        = {4{CH_QMARK}};
    ent.count       = 3'd0;
    ent.last        = 1'b0;

    if (end_of_field) begin
      ent.data[0]     = CH_NUL;
      ent.count       = 3'd1;
      ent.last        = 1'b1;
      pend_count_next = '0;
      trail_next      = '0;
      acc_next        = '0;
      full_next       = 1'b0;
    end else if (!full) begin
      if (pend_count == 2'd0 || !is_cont) begin
        // Open sequence (if any) breaks: buffered bytes go out as '?',
        // then this byte is taken as a fresh lead.
        pend_count_next = '0;
        trail_next      = '0;
        acc_next        = '0;
        if (fits) begin
          if (is_ascii) begin
            ent.data[pend_count] = is_ctl ? CH_SPACE : in_byte;
            ent.count            = 3'(pend_count) + 3'd1;
          end else if (lead2 | lead3 | lead4) begin
            ent.count       = 3'(pend_count);
            pend_next[0]    = in_byte;
            pend_count_next = 2'd1;
            if (lead2) begin
              trail_next = 2'd1;
              acc_next   = 21'(in_byte[4:0]);
            end else if (lead3) begin
              trail_next = 2'd2;
              acc_next   = 21'(in_byte[3:0]);
            end else begin
              trail_next = 2'd3;
              acc_next   = 21'(in_byte[2:0]);
            end
          end else begin
            ent.count = 3'(pend_count) + 3'd1;
          end
        end else begin
          ent.count = rm[2:0];
          full_next = 1'b1;
        end
      end else if (pend_count < trail) begin
        pend_next[pend_count] = in_byte;
        pend_count_next       = pend_count + 2'd1;
        acc_next              = acc_cont;
      end else begin
        // Sequence complete.
        pend_count_next = '0;
        trail_next      = '0;
        acc_next        = '0;
        if (cp_ok) begin
          if (fits) begin
            ent.data[0]          = pend[0];
            ent.data[1]          = pend[1];
            ent.data[2]          = pend[2];
            ent.data[pend_count] = in_byte;
            ent.count            = 3'(pend_count) + 3'd1;
          end else begin
            full_next = 1'b1;
          end
        end else if (fits) begin
          ent.count = 3'(pend_count) + 3'd1;
        end else begin
          ent.count = rm[2:0];
          full_next = 1'b1;
        end
      end
    end

    if (end_of_field) used_next = '0;
    else              used_next = used + CAP_W'(ent.count);
  end

  assign qwr.push  = accept & (ent.count != 3'd0);
  assign qwr.entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      trail      <= '0;
      acc        <= '0;
      used       <= '0;
      full       <= 1'b0;
    end else if (accept) begin
      pend_count <= pend_count_next;
      trail      <= trail_next;
      acc        <= acc_next;
      used       <= used_next;
      full       <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= pend_next;
  end

endmodule
`default_nettype wire

FILE: design/ufs_queue.sv
// Short FIFO of result entries between front and back ends.
// Uses ufs_pkg for the entry type and depth.
`default_nettype none
module ufs_queue
  import ufs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ufs_qwr_t qwr,
  output logic          room,
  output ufs_qrd_t      qrd,
  input  wire logic     pop
);

  ufs_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push, do_pop;

  assign room      = fill != (QPTR_W+1)'(QDEPTH);
  assign qrd.valid = fill != '0;
  assign qrd.entry = mem[rd_ptr];
  assign do_push   = qwr.push & room;
  assign do_pop    = pop & qrd.valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= qwr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/ufs_back.sv
// Back end: walks the head entry of the queue one byte per output
// transaction and pops it after its last byte. Uses ufs_pkg.
`default_nettype none
module ufs_back
  import ufs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ufs_qrd_t qrd,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [7:0]    out_byte,
  output logic          last
);

  logic [1:0] idx, idx_next;
  logic       take, at_end;

  assign out_valid = qrd.valid;
  assign out_byte  = qrd.entry.data[idx];
  assign at_end    = {1'b0, idx} == (qrd.entry.count - 3'd1);
  assign last      = qrd.entry.last & at_end;
  assign take      = out_valid & out_ready;
  assign pop       = take & at_end;

  always_comb begin
    idx_next = idx;
    if (take) idx_next = at_end ? 2'd0 : idx + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) idx <= '0;
    else     idx <= idx_next;
  end

endmodule
`default_nettype wire

FILE: design/utf8_field_sanitizer.sv
// Top level of the UTF-8 field sanitizer: capacity register, front end,
// result queue and back end. Depends on ufs_pkg, ufs_front, ufs_queue, ufs_back.
// Each result entry is registered in the queue before the back end presents it.
// Throughput: one input transaction per cycle while the 4-entry queue has room;
//   the back end drains one output byte per cycle while out_ready is high.
//   Items with no result push no entry into the queue.
// Reset (rst, synchronous): field state and queue cleared, out_capacity = 64.
`default_nettype none
module utf8_field_sanitizer
  import ufs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_field,
  // output channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  last
);

  // Capacity in bytes including the NUL; zero and oversize values are
  // clamped in the front end at use.
  logic [CAP_W-1:0] out_capacity;

  ufs_qwr_t qwr;
  ufs_qrd_t qrd;
  logic     q_room;
  logic     pop;

  always_ff @(posedge clk) begin
    if (rst)            out_capacity <= CAP_RESET;
    else if (cfg_wr_en) out_capacity <= cfg_wr_data;
  end

  // Front end: one input transaction per cycle while the queue has room, classifies the byte and
  // produces a group of up to four result bytes.
  ufs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_field (end_of_field),
    .capacity     (out_capacity),
    .q_room       (q_room),
    .qwr          (qwr)
  );

  // Decouples the byte-per-item front from the byte-per-result back.
  ufs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .qwr  (qwr),
    .room (q_room),
    .qrd  (qrd),
    .pop  (pop)
  );

  // Back end: serializes each group onto the output channel.
  ufs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qrd       (qrd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
`default_nettype wire
